/* hw/rtl/krs_pkg.sv */
// ----------------------------------------------------------------------------
// krs_pkg: shared types for the keyed record store
// Beat payloads, the three bit sets of one record, controller states and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package krs_pkg;

  // request mode codes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_SAVE = 1'b1;

  // request beat
  typedef struct packed {
    logic        mode;
    logic [31:0] player_id;
    logic [63:0] unlocked_lo;
    logic [63:0] unlocked_hi;
    logic [63:0] unseen_lo;
    logic [63:0] unseen_hi;
    logic [63:0] visited_lo;
    logic [63:0] visited_hi;
  } req_t;

  // response beat
  typedef struct packed {
    logic        found;
    logic [2:0]  slot;
    logic        evicted;
    logic [63:0] out_unlocked_lo;
    logic [63:0] out_unlocked_hi;
    logic [63:0] out_unseen_lo;
    logic [63:0] out_unseen_hi;
    logic [63:0] out_visited_lo;
    logic [63:0] out_visited_hi;
  } rsp_t;

  // one record's bit sets, one memory row
  typedef struct packed {
    logic [63:0] unlocked_lo;
    logic [63:0] unlocked_hi;
    logic [63:0] unseen_lo;
    logic [63:0] unseen_hi;
    logic [63:0] visited_lo;
    logic [63:0] visited_hi;
  } bits_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_READ
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the request, restart the scan
    logic issue;     // read key and stamp at the scan index
    logic touch;     // restamp the hit slot
    logic store;     // commit a save
    logic row_rd;    // read the bit set row of the hit slot
    logic rsp_zero;  // respond with zero bit sets
    logic rsp_row;   // respond with the row just read
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // every record in use has been read
    logic rd_pend;    // a key and stamp read is being compared
    logic hit;        // key found
    logic mode;       // mode of the held request
  } ctrl_sts_t;

endpackage

/* hw/rtl/keyed_record_store_lru.sv */
// ----------------------------------------------------------------------------
// keyed_record_store_lru: table of records keyed by a 32-bit player ID
// A request beat is taken when start is high and busy is low. A load returns
// the record's three 128-bit bit sets on a hit and restamps it; a save writes
// the record into its own slot, a free slot or the least recently stamped one.
//
// Request channel: req_i with start; busy stays high until the request has
// been resolved. Response channel: rsp_o, valid for one cycle while done_o is
// high; the receiver cannot stall, so each response must be taken then.
// The keys and stamps of the records in use are read one slot a cycle from a
// single memory port; only the records in use, at most RECORD_SLOTS, are
// scanned, and a load hit reads its bit set row after the scan.
// The next request can be accepted in the cycle done_o is shown.
// Reset clears the fill count and the use clock; the memories need no
// clearing pass, since only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module keyed_record_store_lru #(
  parameter int unsigned RECORD_SLOTS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  krs_pkg::req_t  req_i,
  output logic           done_o,
  output krs_pkg::rsp_t  rsp_o
);

  krs_pkg::ctrl_cmd_t cmd;
  krs_pkg::ctrl_sts_t sts;

  // sequencer
  krs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // storage and compare
  krs_dpath #(
    .RECORD_SLOTS (RECORD_SLOTS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

/* hw/rtl/krs_ctrl.sv */
// ----------------------------------------------------------------------------
// krs_ctrl: request sequencer of the keyed record store
// Walks a request through the slot scan, the resolve step and, for a load
// hit, the row read; issues commands to the datapath.
// ----------------------------------------------------------------------------
module krs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  krs_pkg::ctrl_sts_t  sts_i,
  output krs_pkg::ctrl_cmd_t  cmd_o
);

  krs_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= krs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != krs_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      krs_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = krs_pkg::ST_SCAN;
        end
      end
      krs_pkg::ST_SCAN: begin
        if (!sts_i.scan_done) begin
          cmd_o.issue = 1'b1;
        end else if (!sts_i.rd_pend) begin
          state_d = krs_pkg::ST_RESOLVE;
        end
      end
      krs_pkg::ST_RESOLVE: begin
        if (sts_i.mode == krs_pkg::MODE_SAVE) begin
          cmd_o.store    = 1'b1;
          cmd_o.rsp_zero = 1'b1;
          state_d        = krs_pkg::ST_IDLE;
        end else if (sts_i.hit) begin
          cmd_o.touch  = 1'b1;
          cmd_o.row_rd = 1'b1;
          state_d      = krs_pkg::ST_READ;
        end else begin
          cmd_o.rsp_zero = 1'b1;
          state_d        = krs_pkg::ST_IDLE;
        end
      end
      krs_pkg::ST_READ: begin
        cmd_o.rsp_row = 1'b1;
        state_d       = krs_pkg::ST_IDLE;
      end
      default: begin
        state_d = krs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/krs_dpath.sv */
// ----------------------------------------------------------------------------
// krs_dpath: datapath of the keyed record store
// Holds the key, stamp and bit set memories, the fill count and use clock,
// the scan compare and least-stamp tracking, and the response register.
// ----------------------------------------------------------------------------
module krs_dpath #(
  parameter int unsigned RECORD_SLOTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  krs_pkg::req_t       req_i,
  input  krs_pkg::ctrl_cmd_t  cmd_i,
  output krs_pkg::ctrl_sts_t  sts_o,
  output logic                done_o,
  output krs_pkg::rsp_t       rsp_o
);

  localparam int unsigned IW = $clog2(RECORD_SLOTS);
  localparam int unsigned CW = $clog2(RECORD_SLOTS + 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(RECORD_SLOTS);

  // memories
  logic [31:0]    key_mem   [RECORD_SLOTS];
  logic [31:0]    stamp_mem [RECORD_SLOTS];
  krs_pkg::bits_t row_mem   [RECORD_SLOTS];

  krs_pkg::req_t  req_q;
  logic [CW-1:0]  idx_q;
  logic [IW-1:0]  rd_idx_q;
  logic           rd_pend_q;
  logic [31:0]    key_rd_q;
  logic [31:0]    stamp_rd_q;
  logic           hit_q;
  logic [IW-1:0]  hit_idx_q;
  logic [31:0]    min_q;
  logic [IW-1:0]  min_idx_q;
  logic [CW-1:0]  used_q;
  logic [31:0]    clock_q;
  krs_pkg::bits_t row_rd_q;
  krs_pkg::rsp_t  rsp_q;
  krs_pkg::rsp_t  rsp_d;
  logic           done_q;

  logic           full;
  logic [IW-1:0]  where;
  logic [IW+2:0]  where_ext;
  logic [IW+2:0]  hit_ext;
  logic [31:0]    stamp_new;
  krs_pkg::bits_t wr_row;

  assign full      = (used_q == SLOTS_C);
  assign where     = hit_q ? hit_idx_q : (full ? min_idx_q : used_q[IW-1:0]);
  assign where_ext = {3'b000, where};
  assign hit_ext   = {3'b000, hit_idx_q};
  assign stamp_new = clock_q + 32'd1;

  assign wr_row.unlocked_lo = req_q.unlocked_lo;
  assign wr_row.unlocked_hi = req_q.unlocked_hi;
  assign wr_row.unseen_lo   = req_q.unseen_lo;
  assign wr_row.unseen_hi   = req_q.unseen_hi;
  assign wr_row.visited_lo  = req_q.visited_lo;
  assign wr_row.visited_hi  = req_q.visited_hi;

  // request hold
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      key_mem[where] <= req_q.player_id;
    end
    if (cmd_i.issue) begin
      key_rd_q <= key_mem[idx_q[IW-1:0]];
    end
  end

  // stamp memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store || cmd_i.touch) begin
      stamp_mem[where] <= stamp_new;
    end
    if (cmd_i.issue) begin
      stamp_rd_q <= stamp_mem[idx_q[IW-1:0]];
    end
  end

  // bit set memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      row_mem[where] <= wr_row;
    end
    if (cmd_i.row_rd) begin
      row_rd_q <= row_mem[where];
    end
  end

  // scan index and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.issue;
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_idx_q <= idx_q[IW-1:0];
    end
  end

  // key match, first match wins
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_q <= 1'b0;
    end else if (rd_pend_q && !hit_q && (key_rd_q == req_q.player_id)) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q && !hit_q && (key_rd_q == req_q.player_id)) begin
      hit_idx_q <= rd_idx_q;
    end
  end

  // least stamp, lowest index wins a tie
  always_ff @(posedge clk_i) begin
    if (rd_pend_q && ((rd_idx_q == '0) || (stamp_rd_q < min_q))) begin
      min_q     <= stamp_rd_q;
      min_idx_q <= rd_idx_q;
    end
  end

  // fill count and use clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      clock_q <= '0;
    end else begin
      if (cmd_i.store && !hit_q && !full) begin
        used_q <= used_q + CW'(1);
      end
      if (cmd_i.store || cmd_i.touch) begin
        clock_q <= stamp_new;
      end
    end
  end

  // response next value
  always_comb begin
    rsp_d = '0;
    if (cmd_i.rsp_zero) begin
      if (req_q.mode == krs_pkg::MODE_SAVE) begin
        rsp_d.found   = hit_q;
        rsp_d.slot    = where_ext[2:0];
        rsp_d.evicted = !hit_q && full;
      end
    end else if (cmd_i.rsp_row) begin
      rsp_d.found           = 1'b1;
      rsp_d.slot            = hit_ext[2:0];
      rsp_d.evicted         = 1'b0;
      rsp_d.out_unlocked_lo = row_rd_q.unlocked_lo;
      rsp_d.out_unlocked_hi = row_rd_q.unlocked_hi;
      rsp_d.out_unseen_lo   = row_rd_q.unseen_lo;
      rsp_d.out_unseen_hi   = row_rd_q.unseen_hi;
      rsp_d.out_visited_lo  = row_rd_q.visited_lo;
      rsp_d.out_visited_hi  = row_rd_q.visited_hi;
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_zero || cmd_i.rsp_row) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.rsp_zero || cmd_i.rsp_row;
    end
  end

  // status
  assign sts_o.scan_done = (idx_q == used_q);
  assign sts_o.rd_pend   = rd_pend_q;
  assign sts_o.hit       = hit_q;
  assign sts_o.mode      = req_q.mode;

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
